// ----- hdl/vectored_interrupt_controller_assert.svh -----
`ifndef VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during rst
`define VIC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vic assertion failed");

// next-cycle implication
`define VIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vic assertion failed");

`endif

// ----- hdl/vic_pkg.sv -----
package vic_pkg;

  typedef enum logic [1:0] {
    FUNC_RAISE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } vic_func_t;

  localparam logic [9:0] IDX_IRQ_STATUS = 10'd0;
  localparam logic [9:0] IDX_FIQ_STATUS = 10'd1;
  localparam logic [9:0] IDX_RAW_STATUS = 10'd2;
  localparam logic [9:0] IDX_FIQ_SELECT = 10'd3;
  localparam logic [9:0] IDX_ENABLE_SET = 10'd4;
  localparam logic [9:0] IDX_ENABLE_CLR = 10'd5;
  localparam logic [9:0] IDX_SOFT_INT   = 10'd6;
  localparam logic [9:0] IDX_SOFT_CLR   = 10'd7;
  localparam logic [9:0] IDX_PROTECTION = 10'd8;
  localparam logic [9:0] IDX_PRIO_MASK  = 10'd9;
  localparam logic [9:0] IDX_DAISY      = 10'd10;
  localparam logic [9:0] IDX_VEC_BASE   = 10'd64;
  localparam logic [9:0] IDX_PRI_BASE   = 10'd128;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_n;
    logic        fiq_n;
  } vic_rsp_t;

endpackage

// ----- hdl/vic_cmd_if.sv -----
interface vic_cmd_if;
  import vic_pkg::*;

  logic        valid;
  logic        ready;
  vic_func_t   func;
  logic [4:0]  line;
  logic [9:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, func, line, reg_index, write_data, input ready);
  modport sink (input valid, func, line, reg_index, write_data, output ready);
endinterface

// ----- hdl/vic_rsp_if.sv -----
interface vic_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_n;
  logic        fiq_n;

  modport source (output valid, read_data, irq_n, fiq_n, input ready);
  modport sink (input valid, read_data, irq_n, fiq_n, output ready);
endinterface

// ----- hdl/vectored_interrupt_controller.sv -----
// Vectored interrupt controller, 32 lines.
// cmd carries one event per transfer: a line raise, a bus read or a bus
// write of a register word (control words 0-10, vector table 64 on,
// priority table 128 on). rsp carries one result per event: the read
// word (zero for raises, writes and unknown indices) and the active-low
// irq_n / fiq_n levels taken from the status words after the event.
// From the cmd transfer to rsp valid a result passes the memory stage,
// for the synchronous table memory read, and then the output register.
// Throughput is one event per cycle while rsp ready holds; every event is a single
// read-modify-write of the control registers and one table memory access.
// Table writes complete at the cmd transfer, so a following read of the
// same entry sees the new value with no interlock.
// Reset clears all control state and the table valid bits at once; table
// entries never written read as zero. No clearing pass is needed.
// When the receiver stalls, the result waits in the output register and
// one more event is held in the memory stage; cmd ready drops only when
// both are full.
`include "vectored_interrupt_controller_assert.svh"

module vectored_interrupt_controller import vic_pkg::*; #(
  parameter int NUM_LINES = 32
) (
  input logic      clk,
  input logic      rst,
  vic_cmd_if.sink  cmd,
  vic_rsp_if.source rsp
);

  logic        acc, s1_valid, s1_move, out_valid;
  vic_rsp_t    reg_rsp, s1_rsp, out_rsp;
  logic [31:0] tbl_rdata;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_move;
  assign acc       = cmd.valid && cmd.ready;

  vic_regs #(.NUM_LINES(NUM_LINES)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .func       (cmd.func),
    .line       (cmd.line),
    .reg_index  (cmd.reg_index),
    .write_data (cmd.write_data),
    .rsp        (reg_rsp)
  );

  vic_table #(.NUM_LINES(NUM_LINES)) u_table (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .func       (cmd.func),
    .reg_index  (cmd.reg_index),
    .write_data (cmd.write_data),
    .rdata      (tbl_rdata)
  );

  // memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rsp <= reg_rsp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_rsp.rdata <= s1_rsp.rdata | tbl_rdata;
      out_rsp.irq_n <= s1_rsp.irq_n;
      out_rsp.fiq_n <= s1_rsp.fiq_n;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rsp.rdata;
  assign rsp.irq_n     = out_rsp.irq_n;
  assign rsp.fiq_n     = out_rsp.fiq_n;

  `VIC_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_move, s1_valid && $stable(s1_rsp))
  `VIC_ASSERT_NEXT(a_acc_fills_s1, acc, s1_valid)
  `VIC_ASSERT_NOW(a_no_overrun, s1_valid && out_valid && !rsp.ready, !cmd.ready)

endmodule

// ----- hdl/vic_regs.sv -----
`include "vectored_interrupt_controller_assert.svh"

module vic_regs import vic_pkg::*; #(
  parameter int NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  vic_func_t   func,
  input  logic [4:0]  line,
  input  logic [9:0]  reg_index,
  input  logic [31:0] write_data,
  output vic_rsp_t    rsp
);

  logic [31:0] raw_status, irq_status, fiq_status, fiq_select, enable_mask;
  logic [31:0] soft_int, soft_int_clear_word, protection_word;
  logic [31:0] priority_mask_word, daisy_word;

  logic [31:0] raw_status_next, irq_status_next, fiq_status_next;
  logic [31:0] fiq_select_next, enable_mask_next, soft_int_next;
  logic [31:0] soft_int_clear_word_next, protection_word_next;
  logic [31:0] priority_mask_word_next, daisy_word_next;
  logic [31:0] rdata, bit_mask;
  logic        line_ok;

  assign line_ok  = {1'b0, line} < 6'(NUM_LINES);
  assign bit_mask = line_ok ? (32'd1 << line) : 32'd0;

  always_comb begin
    raw_status_next          = raw_status;
    irq_status_next          = irq_status;
    fiq_status_next          = fiq_status;
    fiq_select_next          = fiq_select;
    enable_mask_next         = enable_mask;
    soft_int_next            = soft_int;
    soft_int_clear_word_next = soft_int_clear_word;
    protection_word_next     = protection_word;
    priority_mask_word_next  = priority_mask_word;
    daisy_word_next          = daisy_word;
    rdata                    = 32'd0;
    if (func == FUNC_RAISE) begin
      raw_status_next = raw_status | bit_mask;
      irq_status_next = irq_status | (bit_mask & ~fiq_select & enable_mask);
      fiq_status_next = fiq_status | (bit_mask & fiq_select & enable_mask);
    end else if (func == FUNC_READ) begin
      unique case (reg_index)
        IDX_IRQ_STATUS: begin
          rdata           = irq_status;
          irq_status_next = 32'd0;
        end
        IDX_FIQ_STATUS: begin
          rdata           = fiq_status;
          fiq_status_next = 32'd0;
        end
        IDX_RAW_STATUS: begin
          rdata           = raw_status;
          raw_status_next = 32'd0;
        end
        IDX_FIQ_SELECT: rdata = fiq_select;
        IDX_ENABLE_SET: rdata = enable_mask;
        IDX_SOFT_INT:   rdata = soft_int;
        IDX_PROTECTION: rdata = protection_word;
        IDX_PRIO_MASK:  rdata = priority_mask_word;
        IDX_DAISY:      rdata = daisy_word;
        default:        rdata = 32'd0;
      endcase
    end else if (func == FUNC_WRITE) begin
      unique case (reg_index)
        IDX_FIQ_SELECT: fiq_select_next          = write_data;
        IDX_ENABLE_SET: enable_mask_next         = enable_mask | write_data;
        IDX_ENABLE_CLR: enable_mask_next         = enable_mask & ~write_data;
        IDX_SOFT_INT:   soft_int_next            = write_data;
        IDX_SOFT_CLR:   soft_int_clear_word_next = write_data;
        IDX_PROTECTION: protection_word_next     = write_data;
        IDX_PRIO_MASK:  priority_mask_word_next  = write_data;
        IDX_DAISY:      daisy_word_next          = write_data;
        default:        rdata                    = 32'd0;
      endcase
    end
  end

  assign rsp.rdata = rdata;
  assign rsp.irq_n = (irq_status_next == 32'd0);
  assign rsp.fiq_n = (fiq_status_next == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_status          <= 32'd0;
      irq_status          <= 32'd0;
      fiq_status          <= 32'd0;
      fiq_select          <= 32'd0;
      enable_mask         <= 32'd0;
      soft_int            <= 32'd0;
      soft_int_clear_word <= 32'd0;
      protection_word     <= 32'd0;
      priority_mask_word  <= 32'd0;
      daisy_word          <= 32'd0;
    end else if (acc) begin
      raw_status          <= raw_status_next;
      irq_status          <= irq_status_next;
      fiq_status          <= fiq_status_next;
      fiq_select          <= fiq_select_next;
      enable_mask         <= enable_mask_next;
      soft_int            <= soft_int_next;
      soft_int_clear_word <= soft_int_clear_word_next;
      protection_word     <= protection_word_next;
      priority_mask_word  <= priority_mask_word_next;
      daisy_word          <= daisy_word_next;
    end
  end

  `VIC_ASSERT_NEXT(a_irq_read_clears,
    acc && func == FUNC_READ && reg_index == IDX_IRQ_STATUS, irq_status == 32'd0)
  `VIC_ASSERT_NEXT(a_raise_sets_raw,
    acc && func == FUNC_RAISE && line_ok, raw_status[$past(line)])
  `VIC_ASSERT_NEXT(a_fiq_read_clears,
    acc && func == FUNC_READ && reg_index == IDX_FIQ_STATUS, fiq_status == 32'd0)

endmodule

// ----- hdl/vic_table.sv -----
module vic_table import vic_pkg::*; #(
  parameter int NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  vic_func_t   func,
  input  logic [9:0]  reg_index,
  input  logic [31:0] write_data,
  output logic [31:0] rdata
);

  localparam int OFF_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int DEPTH = 2 ** (OFF_W + 1);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [31:0]      mem_q;
  logic             hit_q;
  logic             off_ok, vec_hit, pri_hit, hit;
  logic [OFF_W:0]   addr;

  assign off_ok  = {1'b0, reg_index[4:0]} < 6'(NUM_LINES);
  assign vec_hit = reg_index[9:5] == IDX_VEC_BASE[9:5];
  assign pri_hit = reg_index[9:5] == IDX_PRI_BASE[9:5];
  assign hit     = off_ok && (vec_hit || pri_hit);
  assign addr    = {pri_hit, reg_index[OFF_W-1:0]};

  always_ff @(posedge clk) begin
    if (acc && hit && func == FUNC_WRITE) begin
      mem[addr] <= write_data;
    end
    if (acc) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit_q <= 1'b0;
    end else if (acc) begin
      if (hit && func == FUNC_WRITE) begin
        valid[addr] <= 1'b1;
      end
      hit_q <= hit && func == FUNC_READ && valid[addr];
    end
  end

  assign rdata = hit_q ? mem_q : 32'd0;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

import vic_pkg::*;

class vic_scoreboard;
  int unsigned lines;
  logic [31:0] raw_word, irq_word, fiq_word, fiq_sel, enable;
  logic [31:0] soft_int, soft_clr, protection, prio_mask, daisy;
  logic [31:0] vec_tab [32];
  logic [31:0] pri_tab [32];
  vic_rsp_t    pending_rsp [$];
  int          errors;

  function new(int unsigned n);
    lines = n;
    raw_word = '0;
    irq_word = '0;
    fiq_word = '0;
    fiq_sel = '0;
    enable = '0;
    soft_int = '0;
    soft_clr = '0;
    protection = '0;
    prio_mask = '0;
    daisy = '0;
    foreach (vec_tab[k]) vec_tab[k] = '0;
    foreach (pri_tab[k]) pri_tab[k] = '0;
    errors = 0;
  endfunction

  function int outstanding();
    return pending_rsp.size();
  endfunction

  // accepted cmd transfer: update register state, queue the response
  function void apply_event(vic_func_t f, logic [4:0] ln, logic [9:0] idx, logic [31:0] wd);
    logic [31:0] rd;
    logic [31:0] line_bit;
    vic_rsp_t    want;
    rd = '0;
    case (f)
      FUNC_RAISE: begin
        if (ln < lines) begin
          line_bit = 32'd1 << ln;
          raw_word |= line_bit;
          irq_word |= line_bit & ~fiq_sel & enable;
          fiq_word |= line_bit & fiq_sel & enable;
        end
      end
      FUNC_READ: begin
        case (idx)
          IDX_IRQ_STATUS: begin
            rd = irq_word;
            irq_word = '0;
          end
          IDX_FIQ_STATUS: begin
            rd = fiq_word;
            fiq_word = '0;
          end
          IDX_RAW_STATUS: begin
            rd = raw_word;
            raw_word = '0;
          end
          IDX_FIQ_SELECT: rd = fiq_sel;
          IDX_ENABLE_SET: rd = enable;
          IDX_SOFT_INT:   rd = soft_int;
          IDX_PROTECTION: rd = protection;
          IDX_PRIO_MASK:  rd = prio_mask;
          IDX_DAISY:      rd = daisy;
          default: begin
            if (idx >= IDX_VEC_BASE && idx - IDX_VEC_BASE < lines)
              rd = vec_tab[idx - IDX_VEC_BASE];
            else if (idx >= IDX_PRI_BASE && idx - IDX_PRI_BASE < lines)
              rd = pri_tab[idx - IDX_PRI_BASE];
          end
        endcase
      end
      FUNC_WRITE: begin
        case (idx)
          IDX_FIQ_SELECT: fiq_sel = wd;
          IDX_ENABLE_SET: enable |= wd;
          IDX_ENABLE_CLR: enable &= ~wd;
          IDX_SOFT_INT:   soft_int = wd;
          IDX_SOFT_CLR:   soft_clr = wd;
          IDX_PROTECTION: protection = wd;
          IDX_PRIO_MASK:  prio_mask = wd;
          IDX_DAISY:      daisy = wd;
          default: begin
            if (idx >= IDX_VEC_BASE && idx - IDX_VEC_BASE < lines)
              vec_tab[idx - IDX_VEC_BASE] = wd;
            else if (idx >= IDX_PRI_BASE && idx - IDX_PRI_BASE < lines)
              pri_tab[idx - IDX_PRI_BASE] = wd;
          end
        endcase
      end
      default: ;
    endcase
    want.rdata = rd;
    want.irq_n = (irq_word == '0);
    want.fiq_n = (fiq_word == '0);
    pending_rsp.push_back(want);
  endfunction

  function void check_response(logic [31:0] rd, logic irq_n, logic fiq_n);
    vic_rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("rsp transfer with nothing expected: read_data %h irq_n %b fiq_n %b",
             rd, irq_n, fiq_n);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (rd !== want.rdata) begin
      $error("read_data expected %h actual %h", want.rdata, rd);
      errors++;
    end
    if (irq_n !== want.irq_n) begin
      $error("irq_n expected %b actual %b", want.irq_n, irq_n);
      errors++;
    end
    if (fiq_n !== want.fiq_n) begin
      $error("fiq_n expected %b actual %b", want.fiq_n, fiq_n);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int NUM_LINES = 32;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam logic [9:0] IDX_GAP_LOW = IDX_DAISY + 10'd1;
  localparam logic [9:0] IDX_VEC_LAST = IDX_VEC_BASE + 10'd31;
  localparam logic [9:0] IDX_VEC_PAST = IDX_VEC_BASE + 10'd32;
  localparam logic [9:0] IDX_PRI_PAST = IDX_PRI_BASE + 10'd32;
  localparam logic [9:0] IDX_TOP = 10'h3ff;

  logic          clk;
  logic          rst;
  int unsigned   cycle = 0;
  logic          steady;
  vic_scoreboard book;

  vic_cmd_if cmd ();
  vic_rsp_if rsp ();

  vectored_interrupt_controller #(.NUM_LINES(NUM_LINES)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
  end

  // no idling on either side inside this window
  assign steady = (cycle >= 300) && (cycle < 600);

  task automatic send_event(input vic_func_t f, input logic [4:0] ln, input logic [9:0] idx,
                            input logic [31:0] wd);
    while (!steady && $urandom_range(99) < 17) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.func <= f;
    cmd.line <= ln;
    cmd.reg_index <= idx;
    cmd.write_data <= wd;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    book.apply_event(f, ln, idx, wd);
  endtask

  function automatic logic [9:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 10'($urandom_range(2));
    if (r < 55) return 10'($urandom_range(10, 3));
    if (r < 70) return IDX_VEC_BASE + 10'($urandom_range(31));
    if (r < 85) return IDX_PRI_BASE + 10'($urandom_range(31));
    return 10'($urandom_range(1023));
  endfunction

  task automatic run_random(input int count);
    int          sel;
    int          shape;
    logic [31:0] wd;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_event(FUNC_RAISE, 5'($urandom_range(31)), 10'($urandom), $urandom);
      end else if (sel < 65) begin
        send_event(FUNC_READ, 5'($urandom), pick_index(), $urandom);
      end else if (sel < 95) begin
        shape = $urandom_range(9);
        wd = (shape == 0) ? 32'h0 : (shape == 1) ? 32'hffff_ffff : 32'($urandom);
        send_event(FUNC_WRITE, 5'($urandom), pick_index(), wd);
      end else begin
        send_event(FUNC_NONE, 5'($urandom), 10'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        book.check_response(rsp.read_data, rsp.irq_n, rsp.fiq_n);
      rsp.ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  initial begin
    while (cycle < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    book = new(NUM_LINES);
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.func <= FUNC_RAISE;
    cmd.line <= '0;
    cmd.reg_index <= '0;
    cmd.write_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_event(FUNC_READ, 5'd0, IDX_TOP, 32'h0);
    send_event(FUNC_WRITE, 5'd0, IDX_ENABLE_SET, 32'hffff_ffff);
    send_event(FUNC_WRITE, 5'd0, IDX_FIQ_SELECT, 32'h8000_0001);
    send_event(FUNC_RAISE, 5'd0, 10'd0, 32'h0);
    send_event(FUNC_RAISE, 5'd31, 10'd0, 32'h0);
    send_event(FUNC_RAISE, 5'd7, 10'd0, 32'h0);
    send_event(FUNC_NONE, 5'd31, IDX_TOP, 32'hffff_ffff);
    send_event(FUNC_WRITE, 5'd0, IDX_IRQ_STATUS, 32'hffff_ffff);
    send_event(FUNC_WRITE, 5'd0, IDX_RAW_STATUS, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_FIQ_STATUS, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_IRQ_STATUS, 32'h0);
    send_event(FUNC_WRITE, 5'd0, IDX_ENABLE_CLR, 32'h0000_0080);
    send_event(FUNC_RAISE, 5'd7, 10'd0, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_ENABLE_SET, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_RAW_STATUS, 32'h0);
    send_event(FUNC_WRITE, 5'd0, IDX_VEC_LAST, 32'hffff_ffff);
    send_event(FUNC_WRITE, 5'd0, IDX_PRI_BASE, 32'h5a5a_a5a5);
    send_event(FUNC_WRITE, 5'd0, IDX_SOFT_CLR, 32'hffff_ffff);
    send_event(FUNC_READ, 5'd0, IDX_VEC_LAST, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_PRI_BASE, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_SOFT_CLR, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_ENABLE_CLR, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_GAP_LOW, 32'h0);
    send_event(FUNC_WRITE, 5'd0, IDX_PRI_PAST, 32'hffff_ffff);
    send_event(FUNC_READ, 5'd0, IDX_PRI_PAST, 32'h0);
    send_event(FUNC_READ, 5'd0, IDX_VEC_PAST, 32'h0);

    run_random(650);

    cmd.valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
